>>> sv/srrw_pkg.sv
// Shared widths and types for the selective-repeat receive window.
package srrw_pkg;

    // Field widths of one packet descriptor.
    localparam int SEQ_W    = 31;
    localparam int LEN_W    = 8;
    localparam int HANDLE_W = 16;

    // Stream data width: sequence, length and handle packed, padded to bytes.
    localparam int FIELDS_W = SEQ_W + LEN_W + HANDLE_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    // Result kinds carried on the output user bit.
    localparam logic KIND_REACK   = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    // One stored slot of the window: raw length byte and body handle.
    typedef struct packed {
        logic signed [LEN_W-1:0] length;
        logic [HANDLE_W-1:0]     handle;
    } slot_entry_t;

endpackage

>>> sv/srrw_slot_mem.sv
// Slot storage of the window: one write port, one registered read port.
module srrw_slot_mem
    import srrw_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slot_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output slot_entry_t       rd_data
);

    slot_entry_t ram_reg [DEPTH];
    slot_entry_t rd_data_reg;

    // Write the stored entry of a slot.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/selective_repeat_receive_window.sv
// Selective-repeat receive window: classifies packets, stores them, delivers in-order runs.
// A packet is taken in ST_IDLE and classified in the next; a dropped packet or a
// re-ack frees the input on return to ST_IDLE, a re-ack once the output register is free.
// A stored packet then tests the head slot and reads it from the registered slot memory;
// the run leaves at one result per cycle, set by the single read port, while not stalled.
// Reset (aresetn low, synchronous) clears the expected number, head and occupancy bits.
module selective_repeat_receive_window
    import srrw_pkg::*;
#(
    parameter int WINDOW      = 16,
    parameter int MAX_PAYLOAD = 127
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input packet channel.
    input  logic               s_tvalid,
    output logic               s_tready,
    // s_tdata: seq_num [30:0], length_byte [38:31], body_handle [54:39], zeros above.
    input  logic [TDATA_W-1:0] s_tdata,
    // s_tuser: check_ok.
    input  logic               s_tuser,
    // Result channel.
    output logic               m_tvalid,
    input  logic               m_tready,
    // m_tdata: out_seq [30:0], out_length [38:31], out_handle [54:39], zeros above.
    output logic [TDATA_W-1:0] m_tdata,
    // m_tuser: kind.
    output logic               m_tuser,
    output logic               m_tlast
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLASS = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam int PAD_W = TDATA_W - FIELDS_W;

    logic [1:0] state_reg, state_next;

    // Captured packet.
    logic [SEQ_W-1:0]        seq_reg, seq_next;
    logic                    ok_reg, ok_next;
    logic signed [LEN_W-1:0] len_reg, len_next;
    logic [HANDLE_W-1:0]     handle_reg, handle_next;

    // Window state.
    logic [SEQ_W-1:0]  expected_reg, expected_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [WINDOW-1:0] valid_reg, valid_next;

    // Output register.
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;
    logic               m_tlast_reg, m_tlast_next;

    // Memory ports.
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    slot_entry_t       rd_data;

    logic                    out_free;
    logic [SEQ_W-1:0]        offset;
    logic                    is_old;
    logic                    in_window;
    logic [SLOT_W:0]         slot_sum;
    logic [SLOT_W-1:0]       slot_idx;
    logic [SLOT_W-1:0]       head_inc;
    logic signed [LEN_W-1:0] clamped_len;

    srrw_slot_mem #(
        .DEPTH  (WINDOW),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Classification of the captured packet against the expected number.
    always_comb begin
        offset    = seq_reg - expected_reg;
        is_old    = seq_reg < expected_reg;
        in_window = offset < SEQ_W'(WINDOW);
        slot_sum  = {1'b0, head_reg} + {1'b0, offset[SLOT_W-1:0]};
        if (slot_sum >= (SLOT_W+1)'(WINDOW)) begin
            slot_idx = SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW));
        end else begin
            slot_idx = slot_sum[SLOT_W-1:0];
        end
        if (head_reg == SLOT_W'(WINDOW - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg + 1'b1;
        end
    end

    // Clamp the stored length to the deliverable range.
    always_comb begin
        if (rd_data.length < 0) begin
            clamped_len = '0;
        end else if (rd_data.length > $signed(LEN_W'(MAX_PAYLOAD))) begin
            clamped_len = LEN_W'(MAX_PAYLOAD);
        end else begin
            clamped_len = rd_data.length;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Control sequence: capture, classify and store or re-ack, test the head, deliver the run.
    always_comb begin
        state_next    = state_reg;
        seq_next      = seq_reg;
        ok_next       = ok_reg;
        len_next      = len_reg;
        handle_next   = handle_reg;
        expected_next = expected_reg;
        head_next     = head_reg;
        valid_next    = valid_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        wr_en         = 1'b0;
        wr_addr       = slot_idx;
        wr_data       = '{length: len_reg, handle: handle_reg};
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        s_tready      = 1'b0;

        // The output register empties on a completed transfer.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    seq_next    = s_tdata[SEQ_W-1:0];
                    len_next    = s_tdata[SEQ_W +: LEN_W];
                    handle_next = s_tdata[SEQ_W+LEN_W +: HANDLE_W];
                    ok_next     = s_tuser;
                    state_next  = ST_CLASS;
                end
            end
            ST_CLASS: begin
                if (!ok_reg) begin
                    state_next = ST_IDLE;
                end else if (is_old) begin
                    // Echo an old packet back as a re-ack.
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {PAD_W'(0), handle_reg, len_reg, seq_reg};
                        m_tuser_next  = KIND_REACK;
                        m_tlast_next  = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (!in_window) begin
                    state_next = ST_IDLE;
                end else begin
                    wr_en                = 1'b1;
                    valid_next[slot_idx] = 1'b1;
                    state_next           = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // Start the run only if the head slot is occupied.
                if (valid_reg[head_reg]) begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // Deliver the head slot and prefetch the next one.
                if (out_free) begin
                    m_tvalid_next        = 1'b1;
                    m_tdata_next         = {PAD_W'(0), rd_data.handle, clamped_len,
                                            expected_reg};
                    m_tuser_next         = KIND_DELIVER;
                    m_tlast_next         = !valid_reg[head_inc];
                    valid_next[head_reg] = 1'b0;
                    head_next            = head_inc;
                    expected_next        = expected_reg + 1'b1;
                    rd_addr              = head_inc;
                    if (valid_reg[head_inc]) begin
                        rd_en = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            expected_reg <= '0;
            head_reg     <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            expected_reg <= expected_next;
            head_reg     <= head_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        seq_reg     <= seq_next;
        ok_reg      <= ok_next;
        len_reg     <= len_next;
        handle_reg  <= handle_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> test/selective_repeat_receive_window_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the selective-repeat receive window, with its own window predictor.
module selective_repeat_receive_window_tb
    import srrw_pkg::*;
();

    localparam int WINDOW         = 16;
    localparam int MAX_PAYLOAD    = 127;
    localparam int RESET_CYCLES   = 7;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 24;
    localparam int PHASE_ITEMS    = 38;
    localparam int unsigned SEQ_TOP = 32'h7FFF_FFFF;

    // One packet descriptor as it travels on the input channel.
    typedef struct {
        logic [SEQ_W-1:0]        seq;
        logic                    ok;
        logic signed [LEN_W-1:0] len;
        logic [HANDLE_W-1:0]     handle;
    } packet_t;

    // One re-ack or delivery as it leaves on the result channel.
    typedef struct {
        logic                    kind;
        logic [SEQ_W-1:0]        seq;
        logic signed [LEN_W-1:0] len;
        logic [HANDLE_W-1:0]     handle;
        logic                    last;
    } result_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    // Stimulus and scoreboard storage.
    packet_t     pending_pkts [$];
    result_t     owed_results [$];
    packet_t     next_pkt;
    packet_t     seen_pkt;
    result_t     got_res;
    result_t     want_res;

    // Shadow of the receive window, updated by the predictor on accepted packets.
    logic [SEQ_W-1:0]        win_next_seq;
    int                      win_head;
    int                      win_held;
    logic                    win_valid  [WINDOW];
    logic signed [LEN_W-1:0] win_len    [WINDOW];
    logic [HANDLE_W-1:0]     win_handle [WINDOW];

    // Traffic knobs, set by the sequencer at falling edges.
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        hold_arm      = 1'b0;
    logic        hold_taken;
    int          stall_left;
    int unsigned gen_base;
    int          useful_items;
    int          quiet_cycles;

    // Run statistics and failure count.
    int          errors        = 0;
    int          pkts_taken    = 0;
    int          corrupt_taken = 0;
    int          deliveries    = 0;
    int          reacks        = 0;
    int          longest_run   = 0;

    selective_repeat_receive_window #(
        .WINDOW      (WINDOW),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Window predictor: classify one packet and owe the results it causes.
    task automatic reorder_packet(input packet_t p);
        logic [SEQ_W-1:0] offset;
        int               slot;
        int               n;
        int               clamped;
        result_t          r;
        n = 0;
        if (!p.ok) begin
            return;
        end
        // A packet behind the window is acknowledged again with its raw fields.
        if (p.seq < win_next_seq) begin
            r.kind   = KIND_REACK;
            r.seq    = p.seq;
            r.len    = p.len;
            r.handle = p.handle;
            r.last   = 1'b1;
            owed_results.insert(owed_results.size(), r);
            return;
        end
        offset = p.seq - win_next_seq;
        if (offset >= SEQ_W'(WINDOW)) begin
            return;
        end
        slot = (win_head + int'(offset)) % WINDOW;
        win_len[slot]    = p.len;
        win_handle[slot] = p.handle;
        if (!win_valid[slot]) begin
            win_valid[slot] = 1'b1;
            win_held++;
        end
        // Hand over the in-order run that starts at the head.
        while (n < WINDOW && win_valid[win_head]) begin
            clamped = win_len[win_head];
            if (clamped < 0) begin
                clamped = 0;
            end
            if (clamped > MAX_PAYLOAD) begin
                clamped = MAX_PAYLOAD;
            end
            r.kind   = KIND_DELIVER;
            r.seq    = win_next_seq;
            r.len    = LEN_W'(clamped);
            r.handle = win_handle[win_head];
            win_valid[win_head] = 1'b0;
            win_head     = (win_head + 1) % WINDOW;
            win_next_seq = win_next_seq + 1'b1;
            if (win_held > 0) begin
                win_held--;
            end
            n++;
            r.last = (n == WINDOW) || !win_valid[win_head];
            owed_results.insert(owed_results.size(), r);
        end
        if (n > longest_run) begin
            longest_run = n;
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic queue_packet(input int unsigned seq, input bit ok, input int unsigned len,
                                input int unsigned handle);
        packet_t p;
        p.seq    = seq[SEQ_W-1:0];
        p.ok     = ok;
        p.len    = len[LEN_W-1:0];
        p.handle = handle[HANDLE_W-1:0];
        pending_pkts.insert(pending_pkts.size(), p);
    endtask

    // One well-formed run of k packets from the current base, in shuffled order,
    // with corrupted, old, far-ahead and duplicate packets mixed in.
    task automatic queue_run(input int k);
        int          order [WINDOW];
        int          j;
        int          pick;
        int          tmp;
        int unsigned lo;
        for (j = 0; j < k; j++) begin
            order[j] = j;
        end
        for (j = k - 1; j > 0; j--) begin
            pick        = $urandom_range(0, j);
            tmp         = order[j];
            order[j]    = order[pick];
            order[pick] = tmp;
        end
        // The head is still at the base here, so one window past it is just out of reach.
        if ($urandom_range(0, 4) == 0) begin
            queue_packet(gen_base + WINDOW, 1'b1, $urandom, $urandom);
        end
        for (j = 0; j < k; j++) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: queue_packet($urandom, 1'b0, $urandom, $urandom);
                    1: begin
                        queue_packet($urandom_range(0, gen_base - 1), 1'b1, $urandom, $urandom);
                        useful_items++;
                    end
                    2: begin
                        lo = gen_base + k + WINDOW;
                        queue_packet(lo + $urandom_range(0, SEQ_TOP - lo), 1'b1, $urandom,
                                     $urandom);
                    end
                    default: begin
                        if (j > 0) begin
                            queue_packet(gen_base + order[$urandom_range(0, j - 1)], 1'b1,
                                         $urandom, $urandom);
                            useful_items++;
                        end
                    end
                endcase
            end
            queue_packet(gen_base + order[j], 1'b1, $urandom, $urandom);
            useful_items++;
        end
        gen_base += k;
    endtask

    task automatic queue_random(input int count, input bit full_runs);
        int target;
        target = useful_items + count;
        while (useful_items < target) begin
            queue_run(full_runs ? WINDOW : int'($urandom_range(1, WINDOW)));
        end
    endtask

    task automatic wait_drained();
        while (pending_pkts.size() != 0 || s_tvalid || owed_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Sender: offer the next pending packet, with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_pkts.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_pkt = pending_pkts.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(TDATA_W - FIELDS_W){1'b0}}, next_pkt.handle, next_pkt.len,
                             next_pkt.seq};
                s_tuser  <= next_pkt.ok;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when armed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_taken <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            m_tready   <= 1'b0;
            stall_left <= LONG_HOLD;
            hold_taken <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                seen_pkt.seq    = s_tdata[SEQ_W-1:0];
                seen_pkt.len    = s_tdata[SEQ_W +: LEN_W];
                seen_pkt.handle = s_tdata[SEQ_W + LEN_W +: HANDLE_W];
                seen_pkt.ok     = s_tuser;
                pkts_taken++;
                if (!s_tuser) begin
                    corrupt_taken++;
                end
                reorder_packet(seen_pkt);
            end
            if (m_tvalid && m_tready) begin
                got_res.kind   = m_tuser;
                got_res.seq    = m_tdata[SEQ_W-1:0];
                got_res.len    = m_tdata[SEQ_W +: LEN_W];
                got_res.handle = m_tdata[SEQ_W + LEN_W +: HANDLE_W];
                got_res.last   = m_tlast;
                if (got_res.kind == KIND_DELIVER) begin
                    deliveries++;
                end else begin
                    reacks++;
                end
                if (owed_results.size() == 0) begin
                    $error("unexpected result transfer: out_seq %0d, nothing owed", got_res.seq);
                    errors++;
                end else begin
                    want_res = owed_results.pop_front();
                    check_field("kind", want_res.kind, got_res.kind);
                    check_field("out_seq", want_res.seq, got_res.seq);
                    check_field("out_length", want_res.len, got_res.len);
                    check_field("out_handle", want_res.handle, got_res.handle);
                    check_field("last", want_res.last, got_res.last);
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transfer on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", quiet_cycles);
            $display("** selective_repeat_receive_window: FAILED **");
            $finish;
        end
    end

    // Sequencer: reset, directed packets, then random phases with varied traffic.
    initial begin
        int k;
        win_next_seq = '0;
        win_head     = 0;
        win_held     = 0;
        for (k = 0; k < WINDOW; k++) begin
            win_valid[k]  = 1'b0;
            win_len[k]    = '0;
            win_handle[k] = '0;
        end
        useful_items = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: drops, overwrite, no run yet, a two-packet run, re-acks at the extremes.
        queue_packet(0, 1'b0, 8'h05, 16'h0001);
        queue_packet(SEQ_TOP, 1'b1, 8'h7F, 16'hFFFF);
        queue_packet(WINDOW, 1'b1, 8'h10, 16'h0002);
        queue_packet(1, 1'b1, 8'h80, 16'hFFFF);
        queue_packet(1, 1'b1, 8'h7F, 16'h0000);
        queue_packet(0, 1'b1, 8'h00, 16'h1234);
        queue_packet(0, 1'b1, 8'h80, 16'hFFFF);
        queue_packet(1, 1'b1, 8'h7F, 16'h0000);
        // Fill the whole window behind a missing head, then release all of it at once.
        for (k = 3; k < 3 + WINDOW - 1; k++) begin
            queue_packet(k, 1'b1, (k % 3 == 0) ? 32'hFF : $urandom, $urandom);
        end
        queue_packet(2, 1'b1, 8'h01, 16'h8000);
        gen_base = 2 + WINDOW;

        // Random phases: no idling, sender gaps, receiver stalls, then both.
        queue_random(PHASE_ITEMS, 1'b0);
        wait_drained();
        send_idle_pct = 51;
        queue_random(PHASE_ITEMS, 1'b0);
        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 51;
        queue_random(PHASE_ITEMS, 1'b0);
        wait_drained();
        send_idle_pct = 10;
        stall_pct     = 10;
        queue_random(PHASE_ITEMS, 1'b0);
        wait_drained();

        // Back-pressure: full runs while the receiver holds off for a long stretch.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_arm      = 1'b1;
        queue_random(PHASE_ITEMS, 1'b1);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (owed_results.size() != 0) begin
            $error("%0d results never arrived", owed_results.size());
            errors++;
        end
        $display("Covered %0d packets (%0d corrupted) across five traffic phases.",
                 pkts_taken, corrupt_taken);
        $display("Checked %0d deliveries and %0d re-acks; longest in-order run %0d.",
                 deliveries, reacks, longest_run);
        if (errors == 0) begin
            $display("** selective_repeat_receive_window: PASSED **");
        end else begin
            $display("** selective_repeat_receive_window: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/srrw_pkg.sv
sv/srrw_slot_mem.sv
sv/selective_repeat_receive_window.sv
test/selective_repeat_receive_window_tb.sv
